FILE: sv/swept_sphere_collision_test_unit_macros.svh
// assertion macros shared by the swept sphere collision test unit
`ifndef SWEPT_SPHERE_COLLISION_TEST_UNIT_MACROS_SVH
`define SWEPT_SPHERE_COLLISION_TEST_UNIT_MACROS_SVH
`ifndef ASSERT_OFF
`define SSCT_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define SSCT_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define SSCT_ASSERT_IMP(label, clk, rst, ante, cons)
`define SSCT_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

FILE: sv/ssct_pkg.sv
// types, widths and register codes of the swept sphere collision test unit
`timescale 1ns / 1ps
`default_nettype none
package ssct_pkg;

   localparam int FRAC_BITS = 16;
   // width of the exact dot product sums
   localparam int PROD_W    = 70;
   localparam int BP_W      = PROD_W - FRAC_BITS;
   localparam int NB_W      = BP_W + 1;
   localparam int DISC_W    = 2 * BP_W;
   localparam int ROOT_W    = BP_W;
   localparam int NUM_W     = NB_W + FRAC_BITS;
   localparam int QUO_W     = 32;
   localparam int REM_W     = NB_W + QUO_W;
   localparam int CHK_W     = (NUM_W > REM_W ? NUM_W : REM_W) + 1;
   localparam int MUL_W     = 64;
   localparam int HALF_W    = MUL_W / 2;
   localparam int PRD_W     = 2 * MUL_W;
   localparam int CSR_IDX_W = 3;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CENTER_X      = 3'd0,
      CSR_CENTER_Y      = 3'd1,
      CSR_CENTER_Z      = 3'd2,
      CSR_SPHERE_RADIUS = 3'd3,
      CSR_INSIDE_MODE   = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic signed [31:0] start_x;
      logic signed [31:0] start_y;
      logic signed [31:0] start_z;
      logic signed [31:0] move_x;
      logic signed [31:0] move_y;
      logic signed [31:0] move_z;
      logic [31:0]        move_len_sqr;
      logic [30:0]        moving_radius;
      logic [31:0]        best_lambda;
   } ssct_req_type;

   typedef struct packed {
      logic               hit;
      logic [31:0]        hit_lambda;
      logic signed [31:0] contact_x;
      logic signed [31:0] contact_y;
      logic signed [31:0] contact_z;
   } ssct_rsp_type;

   // per word data that rides along the pipeline
   typedef struct packed {
      logic signed [32:0]      d_x;
      logic signed [32:0]      d_y;
      logic signed [32:0]      d_z;
      logic signed [31:0]      m_x;
      logic signed [31:0]      m_y;
      logic signed [31:0]      m_z;
      logic [31:0]             len_sqr;
      logic [31:0]             best;
      logic                    keep_in;
      logic signed [BP_W-1:0]  bp;
      logic signed [BP_W-1:0]  cp;
      logic                    disc_neg;
   } ssct_side_type;

endpackage
`default_nettype wire

FILE: sv/ssct_mul.sv
// two stage signed 64x64 multiplier built from 32x32 partial products
`timescale 1ns / 1ps
`default_nettype none
module ssct_mul import ssct_pkg::*; (
   input  logic                     clock,
   input  logic                     adv,
   input  logic signed [MUL_W-1:0]  a_in,
   input  logic signed [MUL_W-1:0]  b_in,
   output logic signed [PRD_W-1:0]  p_out
);

   logic [MUL_W-1:0] a_mag;
   logic [MUL_W-1:0] b_mag;
   logic [MUL_W-1:0] pp_ll_ff, pp_lh_ff, pp_hl_ff, pp_hh_ff;
   logic [MUL_W-1:0] pp_ll_in, pp_lh_in, pp_hl_in, pp_hh_in;
   logic             neg_ff;
   logic [PRD_W-1:0] sum;
   logic [PRD_W-1:0] p_in;
   logic [PRD_W-1:0] p_ff;

   always_comb begin
      a_mag    = a_in[MUL_W-1] ? MUL_W'(-a_in) : MUL_W'(a_in);
      b_mag    = b_in[MUL_W-1] ? MUL_W'(-b_in) : MUL_W'(b_in);
      pp_ll_in = MUL_W'(a_mag[HALF_W-1:0]) * MUL_W'(b_mag[HALF_W-1:0]);
      pp_lh_in = MUL_W'(a_mag[HALF_W-1:0]) * MUL_W'(b_mag[MUL_W-1:HALF_W]);
      pp_hl_in = MUL_W'(a_mag[MUL_W-1:HALF_W]) * MUL_W'(b_mag[HALF_W-1:0]);
      pp_hh_in = MUL_W'(a_mag[MUL_W-1:HALF_W]) * MUL_W'(b_mag[MUL_W-1:HALF_W]);
   end

   always_comb begin
      sum  = PRD_W'(pp_ll_ff) + (PRD_W'(pp_lh_ff) << HALF_W)
           + (PRD_W'(pp_hl_ff) << HALF_W) + (PRD_W'(pp_hh_ff) << MUL_W);
      p_in = neg_ff ? -sum : sum;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pp_ll_ff <= pp_ll_in;
         pp_lh_ff <= pp_lh_in;
         pp_hl_ff <= pp_hl_in;
         pp_hh_ff <= pp_hh_in;
         neg_ff   <= a_in[MUL_W-1] ^ b_in[MUL_W-1];
         p_ff     <= p_in;
      end
   end

   assign p_out = $signed(p_ff);

endmodule
`default_nettype wire

FILE: sv/ssct_sqrt.sv
// pipelined integer square root, one root bit per stage
`timescale 1ns / 1ps
`default_nettype none
module ssct_sqrt import ssct_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 adv,
   input  logic                 in_valid,
   input  ssct_side_type        in_side,
   input  logic [DISC_W-1:0]    in_rad,
   output logic                 out_valid,
   output ssct_side_type        out_side,
   output logic [ROOT_W-1:0]    out_root
);

   logic                valid_ff [1:ROOT_W];
   ssct_side_type       side_ff  [1:ROOT_W];
   logic [DISC_W-1:0]   rad_ff   [1:ROOT_W];
   logic [ROOT_W+1:0]   rem_ff   [1:ROOT_W];
   logic [ROOT_W-1:0]   root_ff  [1:ROOT_W];

   for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
      logic                src_valid;
      ssct_side_type       src_side;
      logic [DISC_W-1:0]   src_rad;
      logic [ROOT_W+1:0]   src_rem;
      logic [ROOT_W-1:0]   src_root;
      logic [ROOT_W+3:0]   cat;
      logic [ROOT_W+3:0]   trial;
      logic [ROOT_W+3:0]   diff;
      logic                ge;
      logic [ROOT_W+1:0]   rem_in;
      logic [ROOT_W-1:0]   root_in;
      logic [DISC_W-1:0]   rad_in;

      if (k == 0) begin : g_first
         assign src_valid = in_valid;
         assign src_side  = in_side;
         assign src_rad   = in_rad;
         assign src_rem   = '0;
         assign src_root  = '0;
      end else begin : g_rest
         assign src_valid = valid_ff[k];
         assign src_side  = side_ff[k];
         assign src_rad   = rad_ff[k];
         assign src_rem   = rem_ff[k];
         assign src_root  = root_ff[k];
      end

      // bring down the next bit pair and try root*4+1
      always_comb begin
         cat     = {src_rem, src_rad[DISC_W-1 -: 2]};
         trial   = {2'b00, src_root, 2'b01};
         diff    = cat - trial;
         ge      = (cat >= trial);
         rem_in  = ge ? diff[ROOT_W+1:0] : cat[ROOT_W+1:0];
         root_in = {src_root[ROOT_W-2:0], ge};
         rad_in  = {src_rad[DISC_W-3:0], 2'b00};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k+1] <= 1'b0;
         end else if (adv) begin
            valid_ff[k+1] <= src_valid;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            side_ff[k+1] <= src_side;
            rad_ff[k+1]  <= rad_in;
            rem_ff[k+1]  <= rem_in;
            root_ff[k+1] <= root_in;
         end
      end
   end

   assign out_valid = valid_ff[ROOT_W];
   assign out_side  = side_ff[ROOT_W];
   assign out_root  = root_ff[ROOT_W];

endmodule
`default_nettype wire

FILE: sv/swept_sphere_collision_test_unit.sv
// top level of the swept sphere against fixed sphere collision test
//
//   channel  direction  handshake            word
//   req      in         req_valid/req_ready  ssct_req_type (start, motion, radius, best)
//   rsp      out        rsp_valid/rsp_ready  ssct_rsp_type (hit, fraction, contact)
//   csr      in         csr_valid/csr_ready  csr_index + csr_wdata, always ready
//
// one word enters per cycle while the output is not stalled; each word passes through
// the one-bit-per-stage square root and the 32-stage divider.
// reset clears the valid bits and loads the register defaults; no clearing pass.
// a stalled output word freezes the whole pipeline, nothing is dropped or repeated.
`timescale 1ns / 1ps
`default_nettype none
`include "swept_sphere_collision_test_unit_macros.svh"
module swept_sphere_collision_test_unit import ssct_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  ssct_req_type          req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output ssct_rsp_type          rsp_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [31:0]           csr_wdata
);

   typedef struct packed {
      logic den_zero;
      logic lam_neg;
      logic too_big;
   } ssct_dflag_type;

   logic               adv;
   logic signed [31:0] center_x_ff, center_y_ff, center_z_ff;
   logic [30:0]        radius_ff;
   logic               inside_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         center_x_ff <= '0;
         center_y_ff <= '0;
         center_z_ff <= '0;
         radius_ff   <= 31'd65536;
         inside_ff   <= 1'b0;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_CENTER_X:      center_x_ff <= csr_wdata;
            CSR_CENTER_Y:      center_y_ff <= csr_wdata;
            CSR_CENTER_Z:      center_z_ff <= csr_wdata;
            CSR_SPHERE_RADIUS: radius_ff   <= csr_wdata[30:0];
            CSR_INSIDE_MODE:   inside_ff   <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   assign csr_ready = 1'b1;

   logic         out_valid_ff;
   ssct_rsp_type out_ff;

   assign adv       = !out_valid_ff || rsp_ready;
   assign req_ready = adv;

   // stage 0: offsets and combined radius
   logic               s0_valid_ff;
   ssct_side_type      s0_side_ff, s0_side_in;
   logic signed [33:0] s0_r_ff, s0_r_in;

   always_comb begin
      s0_side_in          = '0;
      s0_side_in.m_x      = req_data.move_x;
      s0_side_in.m_y      = req_data.move_y;
      s0_side_in.m_z      = req_data.move_z;
      s0_side_in.len_sqr  = req_data.move_len_sqr;
      s0_side_in.best     = req_data.best_lambda;
      s0_side_in.keep_in  = inside_ff;
      if (inside_ff) begin
         s0_side_in.d_x = 33'(center_x_ff) - 33'(req_data.start_x);
         s0_side_in.d_y = 33'(center_y_ff) - 33'(req_data.start_y);
         s0_side_in.d_z = 33'(center_z_ff) - 33'(req_data.start_z);
         s0_r_in        = 34'(radius_ff) - 34'(req_data.moving_radius);
      end else begin
         s0_side_in.d_x = 33'(req_data.start_x) - 33'(center_x_ff);
         s0_side_in.d_y = 33'(req_data.start_y) - 33'(center_y_ff);
         s0_side_in.d_z = 33'(req_data.start_z) - 33'(center_z_ff);
         s0_r_in        = 34'(radius_ff) + 34'(req_data.moving_radius);
      end
   end

   // stages 1-2: d.m, d.d and r*r products
   logic signed [PRD_W-1:0] p_dm_x, p_dm_y, p_dm_z, p_dd_x, p_dd_y, p_dd_z, p_rr;

   ssct_mul u_mul_dm_x (.clock, .adv, .a_in(64'($signed(s0_side_ff.d_x))),
                        .b_in(64'($signed(s0_side_ff.m_x))), .p_out(p_dm_x));
   ssct_mul u_mul_dm_y (.clock, .adv, .a_in(64'($signed(s0_side_ff.d_y))),
                        .b_in(64'($signed(s0_side_ff.m_y))), .p_out(p_dm_y));
   ssct_mul u_mul_dm_z (.clock, .adv, .a_in(64'($signed(s0_side_ff.d_z))),
                        .b_in(64'($signed(s0_side_ff.m_z))), .p_out(p_dm_z));
   ssct_mul u_mul_dd_x (.clock, .adv, .a_in(64'($signed(s0_side_ff.d_x))),
                        .b_in(64'($signed(s0_side_ff.d_x))), .p_out(p_dd_x));
   ssct_mul u_mul_dd_y (.clock, .adv, .a_in(64'($signed(s0_side_ff.d_y))),
                        .b_in(64'($signed(s0_side_ff.d_y))), .p_out(p_dd_y));
   ssct_mul u_mul_dd_z (.clock, .adv, .a_in(64'($signed(s0_side_ff.d_z))),
                        .b_in(64'($signed(s0_side_ff.d_z))), .p_out(p_dd_z));
   ssct_mul u_mul_rr   (.clock, .adv, .a_in(64'(s0_r_ff)), .b_in(64'(s0_r_ff)),
                        .p_out(p_rr));

   logic          s1_valid_ff, s2_valid_ff;
   ssct_side_type s1_side_ff, s2_side_ff;

   // stage 3: B and C floored to the fraction grid
   logic                    s3_valid_ff;
   ssct_side_type           s3_side_ff, s3_side_in;
   logic signed [PROD_W-1:0] b_sum, c_sum;

   always_comb begin
      b_sum = PROD_W'(p_dm_x) + PROD_W'(p_dm_y) + PROD_W'(p_dm_z);
      c_sum = PROD_W'(p_dd_x) + PROD_W'(p_dd_y) + PROD_W'(p_dd_z) - PROD_W'(p_rr);
      s3_side_in    = s2_side_ff;
      s3_side_in.bp = BP_W'(b_sum >>> FRAC_BITS);
      s3_side_in.cp = BP_W'(c_sum >>> FRAC_BITS);
   end

   // stages 4-5: B*B and a*C
   logic signed [PRD_W-1:0] p_bb, p_ac;

   ssct_mul u_mul_bb (.clock, .adv, .a_in(64'($signed(s3_side_ff.bp))),
                      .b_in(64'($signed(s3_side_ff.bp))), .p_out(p_bb));
   ssct_mul u_mul_ac (.clock, .adv, .a_in(64'(s3_side_ff.len_sqr)),
                      .b_in(64'($signed(s3_side_ff.cp))), .p_out(p_ac));

   logic          s4_valid_ff, s5_valid_ff;
   ssct_side_type s4_side_ff, s5_side_ff;

   // stage 6: discriminant
   logic                     s6_valid_ff;
   ssct_side_type            s6_side_ff, s6_side_in;
   logic [DISC_W-1:0]        s6_rad_ff, s6_rad_in;
   logic signed [DISC_W-1:0] disc;

   always_comb begin
      disc                = DISC_W'(p_bb) - DISC_W'(p_ac);
      s6_side_in          = s5_side_ff;
      s6_side_in.disc_neg = disc[DISC_W-1];
      s6_rad_in           = disc[DISC_W-1] ? '0 : disc;
   end

   logic              sq_valid;
   ssct_side_type     sq_side;
   logic [ROOT_W-1:0] sq_root;

   ssct_sqrt u_sqrt (
      .clock, .reset, .adv,
      .in_valid (s6_valid_ff),
      .in_side  (s6_side_ff),
      .in_rad   (s6_rad_ff),
      .out_valid(sq_valid),
      .out_side (sq_side),
      .out_root (sq_root)
   );

   // stage 7: pick numerator and divisor for the root of this mode
   logic                   s7_valid_ff;
   ssct_side_type          s7_side_ff;
   logic signed [NB_W-1:0] root_s, bp_s, cp_s, nb, den;
   logic [NB_W-1:0]        s7_nmag_ff, s7_nmag_in, s7_dmag_ff, s7_dmag_in;
   ssct_dflag_type         s7_flag_ff, s7_flag_in;

   always_comb begin
      root_s = $signed({1'b0, sq_root});
      bp_s   = NB_W'(sq_side.bp);
      cp_s   = NB_W'(sq_side.cp);
      if (!sq_side.keep_in) begin
         den = root_s - bp_s;
         nb  = cp_s;
      end else if (!sq_side.bp[BP_W-1]) begin
         den = $signed(NB_W'(sq_side.len_sqr));
         nb  = bp_s + root_s;
      end else begin
         den = bp_s - root_s;
         nb  = cp_s;
      end
      s7_nmag_in         = nb[NB_W-1] ? NB_W'(-nb) : NB_W'(nb);
      s7_dmag_in         = den[NB_W-1] ? NB_W'(-den) : NB_W'(den);
      s7_flag_in         = '0;
      s7_flag_in.den_zero = (den == '0);
      s7_flag_in.lam_neg  = (nb != '0) && (nb[NB_W-1] != den[NB_W-1]);
   end

   // stage 8: quotient range check and divider load
   logic               s8_valid_ff;
   ssct_side_type      s8_side_ff;
   ssct_dflag_type     s8_flag_ff, s8_flag_in;
   logic [REM_W-1:0]   s8_rem_ff, s8_rem_in;
   logic [NB_W-1:0]    s8_dmag_ff;
   logic [CHK_W-1:0]   num_sh, den_sh;

   always_comb begin
      num_sh             = CHK_W'({s7_nmag_ff, {FRAC_BITS{1'b0}}});
      den_sh             = CHK_W'({s7_dmag_ff, {QUO_W{1'b0}}});
      s8_flag_in         = s7_flag_ff;
      s8_flag_in.too_big = (num_sh >= den_sh);
      s8_rem_in          = REM_W'(num_sh);
   end

   // stages 9..: restoring divider, one quotient bit per stage
   logic               dv_valid_ff [1:QUO_W];
   ssct_side_type      dv_side_ff  [1:QUO_W];
   ssct_dflag_type     dv_flag_ff  [1:QUO_W];
   logic [REM_W-1:0]   dv_rem_ff   [1:QUO_W];
   logic [NB_W-1:0]    dv_dmag_ff  [1:QUO_W];
   logic [QUO_W-1:0]   dv_q_ff     [1:QUO_W];

   for (genvar k = 0; k < QUO_W; k++) begin : g_div
      localparam int BIT = QUO_W - 1 - k;
      logic             src_valid;
      ssct_side_type    src_side;
      ssct_dflag_type   src_flag;
      logic [REM_W-1:0] src_rem;
      logic [NB_W-1:0]  src_dmag;
      logic [QUO_W-1:0] src_q;
      logic [REM_W:0]   dsh;
      logic [REM_W:0]   rem_x;
      logic             ge;
      logic [REM_W-1:0] rem_in;
      logic [QUO_W-1:0] q_in;

      if (k == 0) begin : g_first
         assign src_valid = s8_valid_ff;
         assign src_side  = s8_side_ff;
         assign src_flag  = s8_flag_ff;
         assign src_rem   = s8_rem_ff;
         assign src_dmag  = s8_dmag_ff;
         assign src_q     = '0;
      end else begin : g_rest
         assign src_valid = dv_valid_ff[k];
         assign src_side  = dv_side_ff[k];
         assign src_flag  = dv_flag_ff[k];
         assign src_rem   = dv_rem_ff[k];
         assign src_dmag  = dv_dmag_ff[k];
         assign src_q     = dv_q_ff[k];
      end

      always_comb begin
         dsh       = (REM_W + 1)'(src_dmag) << BIT;
         rem_x     = {1'b0, src_rem};
         ge        = (rem_x >= dsh);
         rem_in    = ge ? REM_W'(rem_x - dsh) : src_rem;
         q_in      = src_q;
         q_in[BIT] = ge;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_valid_ff[k+1] <= 1'b0;
         end else if (adv) begin
            dv_valid_ff[k+1] <= src_valid;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            dv_side_ff[k+1] <= src_side;
            dv_flag_ff[k+1] <= src_flag;
            dv_rem_ff[k+1]  <= rem_in;
            dv_dmag_ff[k+1] <= src_dmag;
            dv_q_ff[k+1]    <= q_in;
         end
      end
   end

   // decide stage: hit rules
   ssct_side_type    dc_side;
   ssct_dflag_type   dc_flag;
   logic [QUO_W-1:0] dc_q;
   logic             best_pos;
   logic             s9_valid_ff;
   ssct_side_type    s9_side_ff;
   logic             s9_hit_ff, s9_hit_in, s9_have_ff, s9_have_in;
   logic [31:0]      s9_lam_ff, s9_lam_in;

   assign dc_side  = dv_side_ff[QUO_W];
   assign dc_flag  = dv_flag_ff[QUO_W];
   assign dc_q     = dv_q_ff[QUO_W];
   assign best_pos = (dc_side.best != '0);

   always_comb begin
      s9_hit_in  = 1'b0;
      s9_have_in = 1'b0;
      s9_lam_in  = '0;
      if (dc_side.disc_neg) begin
         s9_hit_in = dc_side.keep_in && best_pos;
      end else if (dc_flag.den_zero) begin
         s9_hit_in = 1'b0;
      end else if (!dc_flag.lam_neg) begin
         if (!dc_flag.too_big && (dc_q < dc_side.best)) begin
            s9_hit_in  = 1'b1;
            s9_have_in = 1'b1;
            s9_lam_in  = dc_q;
         end
      end else if (dc_side.keep_in) begin
         s9_hit_in = best_pos;
      end else begin
         // already penetrating and closing in
         s9_hit_in = dc_side.cp[BP_W-1] && dc_side.bp[BP_W-1] && best_pos;
      end
   end

   // contact offsets m*lambda
   logic signed [PRD_W-1:0] p_ml_x, p_ml_y, p_ml_z;

   ssct_mul u_mul_ml_x (.clock, .adv, .a_in(64'($signed(s9_side_ff.m_x))),
                        .b_in(64'(s9_lam_ff)), .p_out(p_ml_x));
   ssct_mul u_mul_ml_y (.clock, .adv, .a_in(64'($signed(s9_side_ff.m_y))),
                        .b_in(64'(s9_lam_ff)), .p_out(p_ml_y));
   ssct_mul u_mul_ml_z (.clock, .adv, .a_in(64'($signed(s9_side_ff.m_z))),
                        .b_in(64'(s9_lam_ff)), .p_out(p_ml_z));

   logic          s10_valid_ff, s11_valid_ff;
   ssct_side_type s10_side_ff, s11_side_ff;
   logic          s10_hit_ff, s11_hit_ff, s10_have_ff, s11_have_ff;
   logic [31:0]   s10_lam_ff, s11_lam_ff;

   function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
      logic signed [31:0] r;
      if (v > 66'sd2147483647) begin
         r = 32'sh7FFFFFFF;
      end else if (v < -66'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   function automatic logic signed [31:0] contact(
      input logic signed [32:0]      d,
      input logic signed [PRD_W-1:0] p,
      input logic                    have,
      input logic                    keep_in
   );
      logic signed [65:0] ds;
      logic signed [65:0] ps;
      logic signed [65:0] v;
      ds = 66'(d);
      ps = 66'(p >>> FRAC_BITS);
      if (!have) begin
         v = ds;
      end else if (keep_in) begin
         v = ds - ps;
      end else begin
         v = ds + ps;
      end
      return sat32(v);
   endfunction

   ssct_rsp_type out_in;

   always_comb begin
      out_in = '0;
      if (s11_hit_ff) begin
         out_in.hit        = 1'b1;
         out_in.hit_lambda = s11_lam_ff;
         out_in.contact_x  = contact(s11_side_ff.d_x, p_ml_x, s11_have_ff,
                                     s11_side_ff.keep_in);
         out_in.contact_y  = contact(s11_side_ff.d_y, p_ml_y, s11_have_ff,
                                     s11_side_ff.keep_in);
         out_in.contact_z  = contact(s11_side_ff.d_z, p_ml_z, s11_have_ff,
                                     s11_side_ff.keep_in);
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff  <= 1'b0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         s5_valid_ff  <= 1'b0;
         s6_valid_ff  <= 1'b0;
         s7_valid_ff  <= 1'b0;
         s8_valid_ff  <= 1'b0;
         s9_valid_ff  <= 1'b0;
         s10_valid_ff <= 1'b0;
         s11_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         s0_valid_ff  <= req_valid;
         s1_valid_ff  <= s0_valid_ff;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         s4_valid_ff  <= s3_valid_ff;
         s5_valid_ff  <= s4_valid_ff;
         s6_valid_ff  <= s5_valid_ff;
         s7_valid_ff  <= sq_valid;
         s8_valid_ff  <= s7_valid_ff;
         s9_valid_ff  <= dv_valid_ff[QUO_W];
         s10_valid_ff <= s9_valid_ff;
         s11_valid_ff <= s10_valid_ff;
         out_valid_ff <= s11_valid_ff;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (adv) begin
         s0_side_ff  <= s0_side_in;
         s0_r_ff     <= s0_r_in;
         s1_side_ff  <= s0_side_ff;
         s2_side_ff  <= s1_side_ff;
         s3_side_ff  <= s3_side_in;
         s4_side_ff  <= s3_side_ff;
         s5_side_ff  <= s4_side_ff;
         s6_side_ff  <= s6_side_in;
         s6_rad_ff   <= s6_rad_in;
         s7_side_ff  <= sq_side;
         s7_nmag_ff  <= s7_nmag_in;
         s7_dmag_ff  <= s7_dmag_in;
         s7_flag_ff  <= s7_flag_in;
         s8_side_ff  <= s7_side_ff;
         s8_flag_ff  <= s8_flag_in;
         s8_rem_ff   <= s8_rem_in;
         s8_dmag_ff  <= s7_dmag_ff;
         s9_side_ff  <= dc_side;
         s9_hit_ff   <= s9_hit_in;
         s9_have_ff  <= s9_have_in;
         s9_lam_ff   <= s9_lam_in;
         s10_side_ff <= s9_side_ff;
         s10_hit_ff  <= s9_hit_ff;
         s10_have_ff <= s9_have_ff;
         s10_lam_ff  <= s9_lam_ff;
         s11_side_ff <= s10_side_ff;
         s11_hit_ff  <= s10_hit_ff;
         s11_have_ff <= s10_have_ff;
         s11_lam_ff  <= s10_lam_ff;
         out_ff      <= out_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   // a missed word carries all zero fields
   logic rsp_zero;

   assign rsp_zero = (rsp_data.hit_lambda == 32'd0) && (rsp_data.contact_x == 32'sd0)
                  && (rsp_data.contact_y == 32'sd0) && (rsp_data.contact_z == 32'sd0);

   `SSCT_ASSERT_IMP(a_stall_holds_input, clock, reset, rsp_valid && !rsp_ready, !req_ready)
   `SSCT_ASSERT_NXT(a_last_stage_reaches_out, clock, reset, s11_valid_ff && adv, rsp_valid)
   `SSCT_ASSERT_IMP(a_miss_is_zero, clock, reset, rsp_valid && !rsp_data.hit, rsp_zero)
   `SSCT_ASSERT_IMP(a_lambda_needs_hit, clock, reset, rsp_valid && !rsp_zero, rsp_data.hit)

endmodule
`default_nettype wire
